// ----- rtl/signed_tenths_seven_segment_mux_macros.svh -----
// Assertion helpers for the checker file.
// The including module must have clk_i and rst_ni in scope.
`ifndef SIGNED_TENTHS_SEVEN_SEGMENT_MUX_MACROS_SVH
`define SIGNED_TENTHS_SEVEN_SEGMENT_MUX_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SSEG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define SSEG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sseg_pkg.sv -----
package sseg_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_BLANK = 2'd2
  } op_e;

  // Scan positions, left to right
  localparam logic [1:0] POS_SIGN     = 2'd0;
  localparam logic [1:0] POS_HUNDREDS = 2'd1;
  localparam logic [1:0] POS_TENS     = 2'd2;
  localparam logic [1:0] POS_ONES     = 2'd3;

  localparam logic [3:0] CODE_BLANK = 4'd12;
  localparam logic [7:0] SEG_OFF    = 8'hFF;
  localparam logic [7:0] SEG_MINUS  = 8'hBF;
  localparam logic [7:0] DP_MASK    = 8'h80;
  localparam logic [3:0] EN_ALL_OFF = 4'hF;
  localparam logic [3:0] EN_ALL_ON  = 4'h0;

  // Value split into sign, quotient by 100 and remainder
  typedef struct packed {
    logic       neg;
    logic [4:0] q100;
    logic [6:0] rem100;
  } split_t;

  // Active-low glyphs for digit codes; anything else is blank
  function automatic logic [7:0] glyph(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

endpackage

// ----- rtl/signed_tenths_seven_segment_mux.sv -----
// Channel  Dir  tdata                                   tuser
// s_axis   in   [11:0] value_tenths (signed), pad       [1:0] opcode
// m_axis   out  [7:0] segment_drive, [11:8] digit_enable, pad   -
//
// One item per cycle while the output is not stalled; each result passes through the input and drive registers.
// The input register holds the pre-divided value; the second stage updates the
// digit store and scan position and loads the drive register, which is the output.
// Reset: all segments and digits off, scan at the sign position, no result pending.
// An output stall holds the drive register and backs up through the input register.
module signed_tenths_seven_segment_mux (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] value_tenths, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] segment_drive, [11:8] digit_enable, [15:12] zero
);

  sseg_pkg::split_t split;

  // Input stage
  logic             in_valid_q;
  logic [1:0]       op_q;
  sseg_pkg::split_t split_q;

  // Display state and drive registers
  logic [1:0] scan_q,  scan_d;
  logic [3:0] hund_q,  hund_d;
  logic [3:0] tens_q,  tens_d;
  logic [3:0] ones_q,  ones_d;
  logic       sign_q,  sign_d;
  logic [7:0] seg_q,   seg_d;
  logic [3:0] en_q,    en_d;
  logic       out_valid_q;

  logic       advance;
  logic [3:0] hund_dig;
  logic [3:0] tens_dig;
  logic [3:0] ones_dig;
  logic [14:0] tens_prod;
  logic [6:0] tens_x10;

  sseg_split u_split (
    .value_i (s_axis_tdata[11:0]),
    .split_o (split)
  );

  // Second stage moves when the output slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= s_axis_tuser;
      split_q <= split;
    end
  end

  // Digits from the split: hundreds mod 10, tens by 205 / 2^11, ones as remainder
  assign hund_dig  = (split_q.q100 >= 5'd20) ? 4'(split_q.q100 - 5'd20) :
                     (split_q.q100 >= 5'd10) ? 4'(split_q.q100 - 5'd10) :
                     split_q.q100[3:0];
  assign tens_prod = {8'd0, split_q.rem100} * 15'd205;
  assign tens_dig  = tens_prod[14:11];
  assign tens_x10  = {3'd0, tens_dig} * 7'd10;
  assign ones_dig  = 4'(split_q.rem100 - tens_x10);

  // Next display state per item kind
  always_comb begin
    scan_d = scan_q;
    hund_d = hund_q;
    tens_d = tens_q;
    ones_d = ones_q;
    sign_d = sign_q;
    seg_d  = seg_q;
    en_d   = en_q;
    case (sseg_pkg::op_e'(op_q))
      sseg_pkg::OP_LOAD: begin
        sign_d = split_q.neg;
        hund_d = hund_dig;
        tens_d = tens_dig;
        ones_d = ones_dig;
      end
      sseg_pkg::OP_TICK: begin
        case (scan_q)
          sseg_pkg::POS_SIGN:
            seg_d = sign_q ? sseg_pkg::SEG_MINUS : sseg_pkg::SEG_OFF;
          sseg_pkg::POS_HUNDREDS:
            seg_d = (hund_q == 4'd0) ? sseg_pkg::SEG_OFF : sseg_pkg::glyph(hund_q);
          sseg_pkg::POS_TENS:
            seg_d = sseg_pkg::glyph(tens_q) & ~sseg_pkg::DP_MASK;
          default:
            seg_d = sseg_pkg::glyph(ones_q);
        endcase
        en_d   = sseg_pkg::EN_ALL_OFF & ~(4'd1 << scan_q);
        scan_d = scan_q + 2'd1;
      end
      sseg_pkg::OP_BLANK: begin
        hund_d = sseg_pkg::CODE_BLANK;
        tens_d = sseg_pkg::CODE_BLANK;
        ones_d = sseg_pkg::CODE_BLANK;
        seg_d  = sseg_pkg::SEG_OFF;
        en_d   = sseg_pkg::EN_ALL_ON;
      end
      default: begin
        // unused kind: drive repeats unchanged
      end
    endcase
  end

  // Display state, drive and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= sseg_pkg::POS_SIGN;
      hund_q      <= 4'd0;
      tens_q      <= 4'd0;
      ones_q      <= 4'd0;
      sign_q      <= 1'b0;
      seg_q       <= sseg_pkg::SEG_OFF;
      en_q        <= sseg_pkg::EN_ALL_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        scan_q <= scan_d;
        hund_q <= hund_d;
        tens_q <= tens_d;
        ones_q <= ones_d;
        sign_q <= sign_d;
        seg_q  <= seg_d;
        en_q   <= en_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, en_q, seg_q};

endmodule

// ----- rtl/sseg_split.sv -----
// Magnitude of the signed value, split into hundreds-and-up and the last two digits
module sseg_split (
  input  logic [11:0]          value_i,
  output sseg_pkg::split_t     split_o
);

  logic [11:0] mag;
  logic [24:0] prod;
  logic [4:0]  q100;
  logic [11:0] q100_x100;

  // Two's complement magnitude; -2048 gives 0x800, which still fits
  assign mag = value_i[11] ? 12'(~value_i + 12'd1) : value_i;

  // Divide by 100 through the reciprocal 5243 / 2^19, exact below 43699
  assign prod      = {13'd0, mag} * 25'd5243;
  assign q100      = prod[23:19];
  assign q100_x100 = {7'd0, q100} * 12'd100;

  assign split_o.neg    = value_i[11];
  assign split_o.q100   = q100;
  assign split_o.rem100 = 7'(mag - q100_x100);

endmodule

// ----- rtl/sseg_checker.sv -----
`include "signed_tenths_seven_segment_mux_macros.svh"

// Port-level checks on the display drive
module sseg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Stalled result holds
  `SSEG_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // At most one digit lit, or all lit for blank
  `SSEG_ASSERT_IMP(a_en_shape, m_axis_tvalid, $onehot(~m_axis_tdata[11:8]) || m_axis_tdata[11:8] == 4'h0 || m_axis_tdata[11:8] == 4'hF, "bad digit enable pattern")

  // Blank drive has every segment off
  `SSEG_ASSERT_IMP(a_blank_seg, m_axis_tvalid && m_axis_tdata[11:8] == 4'h0, m_axis_tdata[7:0] == 8'hFF, "blank drive shows segments")

  // Tens position always carries the decimal point
  `SSEG_ASSERT_IMP(a_tens_dp, m_axis_tvalid && m_axis_tdata[11:8] == 4'b1011, !m_axis_tdata[7], "decimal point missing")

  // Sign position shows minus or nothing
  `SSEG_ASSERT_IMP(a_sign_seg, m_axis_tvalid && m_axis_tdata[11:8] == 4'b1110, m_axis_tdata[7:0] == 8'hBF || m_axis_tdata[7:0] == 8'hFF, "bad sign glyph")

endmodule

bind signed_tenths_seven_segment_mux sseg_checker u_sseg_checker (.*);

// ----- tb/sv/sseg_drive_checker.sv -----
// Watches both stream channels of the display mux, keeps its own copy of the
// digit store and scan state, and compares every output transfer against the
// oldest predicted drive.
module sseg_drive_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] value_tenths, [15:12] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] segment_drive, [11:8] digit_enable, [15:12] zero
  output int          mismatch_count_o,
  output int          drive_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] enables;
  } drive_t;

  // Active-low a..g patterns for digits 0..9, decimal point off
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // Display state as the block should hold it
  logic [1:0] scan_pos;
  logic [3:0] hundreds_digit;
  logic [3:0] tens_digit;
  logic [3:0] ones_digit;
  logic       minus_shown;
  drive_t     drive_now;

  drive_t     drive_expected_q [$];
  int         mismatches = 0;

  function automatic logic [7:0] glyph_for(input logic [3:0] code);
    if (code < 4'd10) return DIGIT_GLYPH[code];
    return sseg_pkg::SEG_OFF;
  endfunction

  // Advance the display state by one input transfer
  task automatic apply_item(input logic [1:0] op, input logic signed [11:0] value);
    int         mag;
    logic [7:0] seg;
    case (op)
      sseg_pkg::OP_LOAD: begin
        minus_shown    = (value < 0);
        mag            = (value < 0) ? -int'(value) : int'(value);
        hundreds_digit = 4'((mag / 100) % 10);
        tens_digit     = 4'((mag / 10) % 10);
        ones_digit     = 4'(mag % 10);
      end
      sseg_pkg::OP_TICK: begin
        case (scan_pos)
          sseg_pkg::POS_SIGN:
            seg = minus_shown ? sseg_pkg::SEG_MINUS : sseg_pkg::SEG_OFF;
          sseg_pkg::POS_HUNDREDS:
            seg = (hundreds_digit == 4'd0) ? sseg_pkg::SEG_OFF : glyph_for(hundreds_digit);
          // decimal point stays lit even over a blank tens digit
          sseg_pkg::POS_TENS:
            seg = glyph_for(tens_digit) & ~sseg_pkg::DP_MASK;
          default:
            seg = glyph_for(ones_digit);
        endcase
        drive_now.segments = seg;
        drive_now.enables  = sseg_pkg::EN_ALL_OFF & ~(4'b0001 << scan_pos);
        scan_pos           = scan_pos + 2'd1;
      end
      sseg_pkg::OP_BLANK: begin
        hundreds_digit     = sseg_pkg::CODE_BLANK;
        tens_digit         = sseg_pkg::CODE_BLANK;
        ones_digit         = sseg_pkg::CODE_BLANK;
        drive_now.segments = sseg_pkg::SEG_OFF;
        drive_now.enables  = sseg_pkg::EN_ALL_ON;
      end
      default: ; // unused opcode leaves everything as it is
    endcase
  endtask

  // Compare outputs first, then predict from the input side
  always @(posedge clk_i) begin
    drive_t got;
    drive_t want;
    if (!rst_ni) begin
      scan_pos           = sseg_pkg::POS_SIGN;
      hundreds_digit     = 4'd0;
      tens_digit         = 4'd0;
      ones_digit         = 4'd0;
      minus_shown        = 1'b0;
      drive_now.segments = sseg_pkg::SEG_OFF;
      drive_now.enables  = sseg_pkg::EN_ALL_OFF;
      drive_expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.segments = m_axis_tdata[7:0];
        got.enables  = m_axis_tdata[11:8];
        if (drive_expected_q.size() == 0) begin
          $error("unexpected output transfer: segment_drive %h digit_enable %h",
                 got.segments, got.enables);
          mismatches++;
        end else begin
          want = drive_expected_q.pop_front();
          if (got.segments !== want.segments) begin
            $error("segment_drive mismatch: expected %h, actual %h",
                   want.segments, got.segments);
            mismatches++;
          end
          if (got.enables !== want.enables) begin
            $error("digit_enable mismatch: expected %h, actual %h",
                   want.enables, got.enables);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(s_axis_tuser, s_axis_tdata[11:0]);
        drive_expected_q.push_back(drive_now);
      end
    end
    mismatch_count_o <= mismatches;
    drive_pending_o  <= drive_expected_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Stimulus and verdict for the signed tenths display mux
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_HALF      = 5;
  localparam int         RANDOM_ITEMS  = 1100;
  localparam int         CYCLE_LIMIT   = 400_000;
  localparam int         DRAIN_CYCLES  = 10;
  localparam int         SQUEEZE_LEN   = 300;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int          mismatch_count;
  int          drive_pending;
  int          cycle_count   = 0;
  logic        random_phase  = 1'b0;
  logic        squeeze_due   = 1'b1;
  logic        burst_mode    = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  signed_tenths_seven_segment_mux i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sseg_drive_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .drive_pending_o  (drive_pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL signed_tenths_seven_segment_mux");
      $finish;
    end
  end

  // Idle cycles before the next offer: mostly none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values biased toward the edges of the digit split
  function automatic logic [11:0] pick_value();
    logic [11:0] corners [10] = '{
      12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'h001,
      12'hC19, 12'h3E7, 12'h064, 12'hF9C, 12'h3E8
    };
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 9)];
    return 12'($urandom_range(0, 4095));
  endfunction

  // Offer one item and return at the edge where it is accepted
  task automatic offer(input logic [1:0] op, input logic [11:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic ticks(input int count);
    repeat (count) offer(sseg_pkg::OP_TICK, pick_value());
  endtask

  // Receiver: random ready pattern, one long hold-off once random items flow
  initial begin
    int   run;
    logic ready;
    wait (rst_ni);
    forever begin
      if (squeeze_due && random_phase) begin
        squeeze_due = 1'b0;
        run         = SQUEEZE_LEN;
        ready       = 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            run   = $urandom_range(1, 8);
            ready = 1'b1;
          end
          10, 11, 12, 13, 14: begin
            run   = $urandom_range(1, 3);
            ready = 1'b0;
          end
          15, 16: begin
            run   = $urandom_range(4, 12);
            ready = 1'b0;
          end
          17: begin
            run   = $urandom_range(20, 50);
            ready = 1'b0;
          end
          default: begin
            run   = $urandom_range(30, 80);
            ready = 1'b1;
          end
        endcase
      end
      repeat (run) begin
        @(posedge clk_i);
        m_axis_tready <= ready;
      end
    end
  end

  // Sender and verdict
  initial begin
    int r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, both extremes, blank with the tens point, unused opcode
    offer(sseg_pkg::OP_LOAD, 12'h000);
    ticks(4);
    offer(sseg_pkg::OP_LOAD, 12'h800);   // -2048, thousands dropped
    ticks(4);
    offer(sseg_pkg::OP_LOAD, 12'h7FF);   // 2047
    ticks(2);
    offer(sseg_pkg::OP_BLANK, 12'h555);
    ticks(2);                             // blank tens still shows its point
    offer(OP_UNUSED, 12'hFFF);
    ticks(1);
    offer(sseg_pkg::OP_LOAD, 12'hFFF);   // -1
    ticks(1);                             // hundreds zero shows blank
    offer(OP_UNUSED, 12'h000);
    offer(sseg_pkg::OP_LOAD, 12'h3E7);   // 999
    ticks(3);

    // Random items, mostly loads and ticks
    random_phase = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 55)      offer(sseg_pkg::OP_TICK, pick_value());
      else if (r < 85) offer(sseg_pkg::OP_LOAD, pick_value());
      else if (r < 93) offer(sseg_pkg::OP_BLANK, pick_value());
      else             offer(OP_UNUSED, pick_value());
    end
    s_axis_tvalid <= 1'b0;

    // Let the pending count take in the last transfer before draining
    @(posedge clk_i);

    // Drain, then give late stray outputs a chance to show up
    while (drive_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && drive_pending == 0) begin
      $display("PASS signed_tenths_seven_segment_mux");
    end else begin
      $display("FAIL signed_tenths_seven_segment_mux");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sseg_pkg.sv
rtl/sseg_split.sv
rtl/signed_tenths_seven_segment_mux.sv
rtl/sseg_checker.sv
tb/sv/sseg_drive_checker.sv
tb/sv/tb.sv
